### hdl/sorted_key_record_table_macros.svh
// assertion macros for the sorted key record table
`ifndef SORTED_KEY_RECORD_TABLE_MACROS_SVH
`define SORTED_KEY_RECORD_TABLE_MACROS_SVH

// condition holds on every clock out of reset
`define SKRT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("skrt invariant violated");

// consequent holds in the cycle after the antecedent
`define SKRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skrt sequence violated");

`endif

### hdl/skrt_pkg.sv
`default_nettype none

package skrt_pkg;

  localparam int CAPACITY = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;
  localparam logic [2:0] ST_FOUND    = 3'd6;
  localparam logic [2:0] ST_ENTRY    = 3'd7;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] key;
    logic [63:0] name_bytes;
    logic [63:0] dept_bytes;
    logic [15:0] marks_in;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] key_out;
    logic [63:0] name_out;
    logic [63:0] dept_out;
    logic [15:0] marks_out;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] key;
    logic [63:0] name;
    logic [63:0] dept;
    logic [15:0] marks;
  } rec_t;

endpackage

`default_nettype wire

### hdl/sorted_key_record_table.sv
// a search reads and compares one record after another, then reports
// insert moves records up, one by one, before the report
// delete moves records down, one by one, after the report
// list gives one record after another; one transaction in work at a time,
// the next is taken once the block is back in idle
// all loops run over the record memory, one read and one write a cycle
// reset clears the record count and control; memory contents stay undefined
`default_nettype none
`include "sorted_key_record_table_macros.svh"

module sorted_key_record_table #(
  parameter int CAPACITY = skrt_pkg::CAPACITY
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire skrt_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output skrt_pkg::out_t     out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] FULL_COUNT = IW'(CAPACITY);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_IRD  = 4'd3;
  localparam logic [3:0] S_IWB  = 4'd4;
  localparam logic [3:0] S_DRD  = 4'd5;
  localparam logic [3:0] S_DWR  = 4'd6;
  localparam logic [3:0] S_LRD  = 4'd7;
  localparam logic [3:0] S_LCMP = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]     state;
  logic [3:0]     post;
  logic [IW-1:0]  idx;
  logic [IW-1:0]  pos;
  logic [IW-1:0]  count;
  logic [IW-1:0]  idx_inc;
  logic [IW-1:0]  idx_dec;
  skrt_pkg::in_t  req;
  skrt_pkg::out_t res;
  skrt_pkg::rec_t mem [CAPACITY];
  skrt_pkg::rec_t rdata;
  skrt_pkg::rec_t wdata;
  skrt_pkg::rec_t new_rec;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic           we;
  logic           full;

  function automatic skrt_pkg::out_t no_rec(input logic [2:0] st, input logic [15:0] k);
    skrt_pkg::out_t o;
    o.status    = st;
    o.key_out   = k;
    o.name_out  = '0;
    o.dept_out  = '0;
    o.marks_out = '0;
    o.last      = 1'b1;
    return o;
  endfunction

  function automatic skrt_pkg::out_t rec_out(input logic [2:0] st, input skrt_pkg::rec_t r,
                                             input logic lst);
    skrt_pkg::out_t o;
    o.status    = st;
    o.key_out   = r.key;
    o.name_out  = r.name;
    o.dept_out  = r.dept;
    o.marks_out = r.marks;
    o.last      = lst;
    return o;
  endfunction

  assign idx_inc  = idx + IW'(1);
  assign idx_dec  = idx - IW'(1);
  assign full     = (count == FULL_COUNT);
  assign in_ready = (state == S_IDLE);

  assign new_rec.key   = req.key;
  assign new_rec.name  = req.name_bytes;
  assign new_rec.dept  = req.dept_bytes;
  assign new_rec.marks = req.marks_in;

  always_comb begin
    raddr = idx[AW-1:0];
    waddr = idx[AW-1:0];
    wdata = rdata;
    we    = 1'b0;
    case (state)
      S_IRD: begin
        raddr = idx_dec[AW-1:0];
        wdata = new_rec;
        we    = (idx == pos);
      end
      S_IWB: we = 1'b1;
      S_DRD: raddr = idx_inc[AW-1:0];
      S_DWR: we = 1'b1;
      default: ;
    endcase
  end

  // record memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      post      <= S_IDLE;
      idx       <= '0;
      pos       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            idx <= '0;
            post <= S_IDLE;
            if (in_data.command == skrt_pkg::CMD_LIST) begin
              if (count == '0) begin
                res   <= no_rec(skrt_pkg::ST_EMPTY, 16'd0);
                state <= S_OUT;
              end else begin
                state <= S_LRD;
              end
            end else if (in_data.command == skrt_pkg::CMD_DELETE && count == '0) begin
              res   <= no_rec(skrt_pkg::ST_EMPTY, in_data.key);
              state <= S_OUT;
            end else begin
              state <= S_SRD;
            end
          end
        end
        S_SRD: begin
          if (idx == count) begin
            if (req.command == skrt_pkg::CMD_INSERT) begin
              if (full) begin
                res   <= no_rec(skrt_pkg::ST_FULL, req.key);
                state <= S_OUT;
              end else begin
                pos   <= idx;
                state <= S_IRD;
              end
            end else begin
              res   <= no_rec(skrt_pkg::ST_NOTFOUND, req.key);
              state <= S_OUT;
            end
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (rdata.key == req.key) begin
            state <= S_OUT;
            case (req.command)
              skrt_pkg::CMD_INSERT: res <= no_rec(skrt_pkg::ST_DUP, req.key);
              skrt_pkg::CMD_DELETE: begin
                res  <= rec_out(skrt_pkg::ST_DELETED, rdata, 1'b1);
                post <= S_DRD;
              end
              default: res <= rec_out(skrt_pkg::ST_FOUND, rdata, 1'b1);
            endcase
          end else if (rdata.key > req.key) begin
            if (req.command == skrt_pkg::CMD_INSERT) begin
              if (full) begin
                res   <= no_rec(skrt_pkg::ST_FULL, req.key);
                state <= S_OUT;
              end else begin
                pos   <= idx;
                idx   <= count;
                state <= S_IRD;
              end
            end else begin
              res   <= no_rec(skrt_pkg::ST_NOTFOUND, req.key);
              state <= S_OUT;
            end
          end else begin
            idx   <= idx_inc;
            state <= S_SRD;
          end
        end
        S_IRD: begin
          if (idx == pos) begin
            count <= count + IW'(1);
            res   <= rec_out(skrt_pkg::ST_ADDED, new_rec, 1'b1);
            state <= S_OUT;
          end else begin
            state <= S_IWB;
          end
        end
        S_IWB: begin
          idx   <= idx_dec;
          state <= S_IRD;
        end
        S_DRD: begin
          if (idx_inc == count) begin
            count <= count - IW'(1);
            state <= S_IDLE;
          end else begin
            state <= S_DWR;
          end
        end
        S_DWR: begin
          idx   <= idx_inc;
          state <= S_DRD;
        end
        S_LRD: state <= S_LCMP;
        S_LCMP: begin
          res   <= rec_out(skrt_pkg::ST_ENTRY, rdata, idx_inc == count);
          post  <= (idx_inc == count) ? S_IDLE : S_LRD;
          idx   <= idx_inc;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= post;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SKRT_ASSERT_ALWAYS(a_count_bound, count <= FULL_COUNT)
  `SKRT_ASSERT_NEXT(a_count_up, state == S_IRD && idx == pos, count == $past(count) + IW'(1))
  `SKRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `SKRT_ASSERT_ALWAYS(a_write_in_range, !we || (IW'(waddr) <= count))

endmodule

`default_nettype wire
